// ===== sv/dksp_pkg.sv =====
// Shared types, widths and register codes for the distance-keeping speed PI unit.
package dksp_pkg;

  localparam int INTEGRATOR_WIDTH = 32;

  localparam int GAIN_W   = 24;
  localparam int DUTY_W   = 15;
  localparam int DIST_W   = 16;
  localparam int TGT_W    = 17;
  localparam int ERR_W    = 19;
  localparam int PP_W     = GAIN_W + 1 + ERR_W;
  localparam int IP_W     = GAIN_W + 1 + INTEGRATOR_WIDTH;
  localparam int I_CAP_LOG = 50;
  localparam int ICAP_W   = I_CAP_LOG + 2;
  localparam int WIDE_W   = (IP_W > ICAP_W) ? IP_W : ICAP_W;
  localparam int ACC_W    = ICAP_W + 1;
  localparam int RND_SH   = 16;
  localparam int Q_W      = ACC_W - RND_SH;

  localparam logic [TGT_W-1:0] MAX_TARGET = TGT_W'(1500);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SH - 1);
  localparam logic signed [WIDE_W-1:0] I_CAP =
    {{(WIDE_W - I_CAP_LOG - 1){1'b0}}, 1'b1, {I_CAP_LOG{1'b0}}};
  localparam logic signed [INTEGRATOR_WIDTH-1:0] SUM_MAX =
    {1'b0, {(INTEGRATOR_WIDTH - 1){1'b1}}};
  localparam logic signed [INTEGRATOR_WIDTH-1:0] SUM_MIN =
    {1'b1, {(INTEGRATOR_WIDTH - 1){1'b0}}};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_DUTY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST      = 3'd7;

  typedef struct packed {
    logic signed [15:0] throttle_cmd;
    logic [15:0]        front_distance;
    logic signed [15:0] wheel_speed;
  } dksp_in_t;

  typedef struct packed {
    logic signed [15:0] duty_out;
    logic               soft_start_active;
  } dksp_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [DUTY_W-1:0] duty_limit;
    logic [DUTY_W-1:0] throttle_threshold;
    logic [DUTY_W-1:0] soft_start_duty;
    logic [DUTY_W-1:0] start_speed;
    logic [DIST_W-1:0] near_distance;
    logic [DIST_W-1:0] far_distance;
  } dksp_cfg_t;

  typedef struct packed {
    logic                               soft_start;
    logic signed [ERR_W-1:0]            err;
    logic signed [INTEGRATOR_WIDTH-1:0] sum;
  } dksp_s1_t;

  typedef struct packed {
    logic                   soft_start;
    logic signed [PP_W-1:0] pprod;
    logic signed [IP_W-1:0] iprod;
  } dksp_s2_t;

endpackage

// ===== sv/dksp_track.sv =====
// Target speed, speed error, saturating integrator and soft-start flag.
module dksp_track (
  input  logic                clk,
  input  logic                rst_n,
  input  dksp_pkg::dksp_cfg_t cfg,
  input  logic                up_valid,
  input  dksp_pkg::dksp_in_t  up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output dksp_pkg::dksp_s1_t  dn_data,
  input  logic                dn_ready
);
  import dksp_pkg::*;

  logic                               started_r;
  logic signed [INTEGRATOR_WIDTH-1:0] sum_r;
  logic                               s1_valid_r;
  dksp_s1_t                           s1_r;

  logic                               fire;
  logic                               enable;
  logic                               soft_start;
  logic                               run_pi;
  logic                               fast;
  logic [DIST_W-1:0]                  span;
  logic [TGT_W:0]                     span3;
  logic [TGT_W-1:0]                   tgt;
  logic [TGT_W-1:0]                   pi_tgt;
  logic signed [ERR_W-1:0]            err;
  logic signed [INTEGRATOR_WIDTH:0]   sum_ext;
  logic signed [INTEGRATOR_WIDTH-1:0] sum_sat;

  assign up_ready = !s1_valid_r || dn_ready;
  assign fire     = up_valid && up_ready;
  assign dn_valid = s1_valid_r;
  assign dn_data  = s1_r;

  always_comb begin
    enable     = up_data.throttle_cmd > $signed({1'b0, cfg.throttle_threshold});
    soft_start = enable && !started_r;
    run_pi     = !soft_start;
    fast       = up_data.wheel_speed > $signed({1'b0, cfg.start_speed});
    span       = up_data.front_distance - cfg.near_distance;
    span3      = (TGT_W + 1)'(span) + (TGT_W + 1)'({span, 1'b0});
    priority if (up_data.front_distance < cfg.near_distance) begin
      tgt = '0;
    end else if (up_data.front_distance < cfg.far_distance) begin
      tgt = span3[TGT_W:1];
    end else begin
      tgt = MAX_TARGET;
    end
    pi_tgt  = enable ? tgt : '0;
    err     = $signed(ERR_W'(pi_tgt)) - ERR_W'(up_data.wheel_speed);
    sum_ext = (INTEGRATOR_WIDTH + 1)'(sum_r) + (INTEGRATOR_WIDTH + 1)'(err);
    priority if (!sum_ext[INTEGRATOR_WIDTH] && sum_ext[INTEGRATOR_WIDTH-1]) begin
      sum_sat = SUM_MAX;
    end else if (sum_ext[INTEGRATOR_WIDTH] && !sum_ext[INTEGRATOR_WIDTH-1]) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = sum_ext[INTEGRATOR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        s1_valid_r <= up_valid;
      end
      if (fire) begin
        if (run_pi) begin
          sum_r <= sum_sat;
        end
        if (!enable) begin
          started_r <= 1'b0;
        end else if (!started_r && fast) begin
          started_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_r.soft_start <= soft_start;
      s1_r.err        <= err;
      s1_r.sum        <= sum_sat;
    end
  end

endmodule

// ===== sv/dksp_mult.sv =====
// Proportional and integral gain products.
module dksp_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  dksp_pkg::dksp_cfg_t cfg,
  input  logic                up_valid,
  input  dksp_pkg::dksp_s1_t  up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output dksp_pkg::dksp_s2_t  dn_data,
  input  logic                dn_ready
);
  import dksp_pkg::*;

  logic     s2_valid_r;
  dksp_s2_t s2_r;

  logic signed [PP_W-1:0] pprod;
  logic signed [IP_W-1:0] iprod;

  assign up_ready = !s2_valid_r || dn_ready;
  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_r;

  always_comb begin
    pprod = $signed({1'b0, cfg.prop_gain}) * up_data.err;
    iprod = $signed({1'b0, cfg.integral_gain}) * up_data.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (up_ready) begin
      s2_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s2_r.soft_start <= up_data.soft_start;
      s2_r.pprod      <= pprod;
      s2_r.iprod      <= iprod;
    end
  end

endmodule

// ===== sv/dksp_out.sv =====
// Integral cap, PI sum, rounding, duty clamp, soft-start duty select and result register.
module dksp_out (
  input  logic                clk,
  input  logic                rst_n,
  input  dksp_pkg::dksp_cfg_t cfg,
  input  logic                up_valid,
  input  dksp_pkg::dksp_s2_t  up_data,
  output logic                up_ready,
  output logic                out_valid,
  output dksp_pkg::dksp_out_t out_data,
  input  logic                out_stall
);
  import dksp_pkg::*;

  logic      out_valid_r;
  dksp_out_t out_r;

  logic signed [WIDE_W-1:0] iwide;
  logic signed [ICAP_W-1:0] iterm;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [Q_W-1:0]    q;
  logic signed [Q_W-1:0]    lim;
  logic signed [Q_W-1:0]    qc;
  logic signed [15:0]       duty;

  assign up_ready  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    iwide = WIDE_W'(up_data.iprod);
    priority if (iwide > I_CAP) begin
      iterm = ICAP_W'(I_CAP);
    end else if (iwide < -I_CAP) begin
      iterm = ICAP_W'(-I_CAP);
    end else begin
      iterm = ICAP_W'(iwide);
    end
    acc    = ACC_W'(up_data.pprod) + ACC_W'(iterm) + RND_HALF;
    acc_sh = acc >>> RND_SH;
    q      = acc_sh[Q_W-1:0];
    lim    = $signed(Q_W'({1'b0, cfg.duty_limit}));
    priority if (q > lim) begin
      qc = lim;
    end else if (q < -lim) begin
      qc = -lim;
    end else begin
      qc = q;
    end
    duty = up_data.soft_start ? $signed({1'b0, cfg.soft_start_duty}) : qc[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      out_r.duty_out          <= duty;
      out_r.soft_start_active <= up_data.soft_start;
    end
  end

endmodule

// ===== sv/distance_keeping_speed_pi_unit.sv =====
// A request goes from the input register through the error/integrator, product and result
// registers. Throughput: one request per cycle while out_stall is low; the integrator and
// start flag close their feedback loop inside the first stage after the input register.
// Four register stages (input, error/integrator, products, result) each stall independently.
// Reset: synchronous; clears valids, start flag and integrator, loads default gains/limits.
module distance_keeping_speed_pi_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  dksp_pkg::dksp_in_t             in_data,
  output logic                           in_stall,
  output logic                           out_valid,
  output dksp_pkg::dksp_out_t            out_data,
  input  logic                           out_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dksp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dksp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dksp_pkg::*;

  dksp_cfg_t cfg_r;
  logic      in_valid_r;
  dksp_in_t  in_r;

  logic      in_ready;
  logic      trk_ready;
  logic      s1_valid;
  dksp_s1_t  s1_data;
  logic      mul_ready;
  logic      s2_valid;
  dksp_s2_t  s2_data;
  logic      out_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = !in_valid_r || trk_ready;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain          <= GAIN_W'(536871);
      cfg_r.integral_gain      <= GAIN_W'(21475);
      cfg_r.duty_limit         <= DUTY_W'(16384);
      cfg_r.throttle_threshold <= DUTY_W'(4915);
      cfg_r.soft_start_duty    <= DUTY_W'(6554);
      cfg_r.start_speed        <= DUTY_W'(1000);
      cfg_r.near_distance      <= DIST_W'(250);
      cfg_r.far_distance       <= DIST_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:     cfg_r.prop_gain          <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN: cfg_r.integral_gain      <= cfg_data[GAIN_W-1:0];
        CFG_DUTY_LIMIT:    cfg_r.duty_limit         <= cfg_data[DUTY_W-1:0];
        CFG_THROTTLE_THR:  cfg_r.throttle_threshold <= cfg_data[DUTY_W-1:0];
        CFG_SOFT_DUTY:     cfg_r.soft_start_duty    <= cfg_data[DUTY_W-1:0];
        CFG_START_SPEED:   cfg_r.start_speed        <= cfg_data[DUTY_W-1:0];
        CFG_NEAR_DIST:     cfg_r.near_distance      <= cfg_data[DIST_W-1:0];
        CFG_FAR_DIST:      cfg_r.far_distance       <= cfg_data[DIST_W-1:0];
        default:           cfg_r.far_distance       <= cfg_r.far_distance;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  dksp_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid_r),
    .up_data  (in_r),
    .up_ready (trk_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data),
    .dn_ready (mul_ready)
  );

  dksp_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s1_valid),
    .up_data  (s1_data),
    .up_ready (mul_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2_data),
    .dn_ready (out_ready)
  );

  dksp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (s2_valid),
    .up_data   (s2_data),
    .up_ready  (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
